// ----- rtl/wlb_pkg.sv -----
// wlb_pkg: shared constants, codes and types of the weighted load balancer.
// Depends on nothing; imported by wlb_ratio_cmp and weighted_load_balancer.
package wlb_pkg;

    localparam int MAX_DEVICES = 8;
    localparam int COUNT_WIDTH = 16;
    localparam int SCORE_W     = 8;
    localparam int DEV_W       = 3;
    localparam int NUM_W       = 4;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 1;
    localparam int LOAD_W      = COUNT_WIDTH + 1;
    localparam int PROD_W      = SCORE_W + LOAD_W;

    // request codes
    localparam logic [1:0] FUNC_ACQ_ONE  = 2'd0;
    localparam logic [1:0] FUNC_ACQ_TEAM = 2'd1;
    localparam logic [1:0] FUNC_RELEASE  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCORE_TABLE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_COUNT = 1'd1;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [DEV_W-1:0]       dev_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_ONE,
        S_SCAN_TEAM,
        S_RAISE,
        S_RELEASE,
        S_ERROR
    } state_t;

endpackage

// ----- rtl/wlb_ratio_cmp.sv -----
// wlb_ratio_cmp: exact ratio compare, score_a/(cnt_a+1) > score_b/(cnt_b+1).
// Cross-multiplied, so no rounding. Uses wlb_pkg.
module wlb_ratio_cmp (
    input  logic [wlb_pkg::SCORE_W-1:0] a_score,
    input  wlb_pkg::count_t             a_count,
    input  logic [wlb_pkg::SCORE_W-1:0] b_score,
    input  wlb_pkg::count_t             b_count,
    output logic                        a_greater
);
    import wlb_pkg::*;

    logic [LOAD_W-1:0] a_load;
    logic [LOAD_W-1:0] b_load;
    logic [PROD_W-1:0] lhs;
    logic [PROD_W-1:0] rhs;

    assign a_load = {1'b0, a_count} + LOAD_W'(1);
    assign b_load = {1'b0, b_count} + LOAD_W'(1);
    // score times the other device's load
    assign lhs = PROD_W'(a_score) * PROD_W'(b_load);
    assign rhs = PROD_W'(b_score) * PROD_W'(a_load);
    assign a_greater = lhs > rhs;

endmodule

// ----- rtl/weighted_load_balancer.sv -----
// weighted_load_balancer: top level. Picks devices by score/(sessions+1).
// Takes one request at a time: a new one is accepted only in idle, after the
// last result of the previous one has been registered.
// A single ratio comparator is stepped over one device a cycle.
// Reset (async, active low) clears scores, device count and all session counts.
module weighted_load_balancer (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration
    input  logic                             cfg_we,
    input  logic [wlb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wlb_pkg::CFG_W-1:0]        cfg_data,
    // request channel
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       func,
    input  logic [3:0]                       team_size,
    input  logic [2:0]                       device_index,
    // result channel
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [2:0]                       chosen_device,
    output logic [1:0]                       status,
    output logic                             last
);
    import wlb_pkg::*;

    // configuration
    logic [CFG_W-1:0]   score_table_reg;
    logic [NUM_W-1:0]   device_count_reg;

    // per-device session counts, read through the scan pointer (entry 0 also directly)
    count_t             counts_reg [MAX_DEVICES];
    count_t             counts_next[MAX_DEVICES];

    // sequencer
    state_t             state_reg, state_next;
    dev_t               ptr_reg, ptr_next;         // device under scan / raise / release
    dev_t               best_idx_reg, best_idx_next;
    logic [SCORE_W-1:0] best_score_reg, best_score_next;
    count_t             best_cnt_reg, best_cnt_next;
    logic               have_reg, have_next;       // team scan has a candidate
    logic [NUM_W-1:0]   team_k_reg, team_k_next;
    logic [NUM_W-1:0]   pick_cnt_reg, pick_cnt_next;
    logic [NUM_W-1:0]   remain_reg, remain_next;   // results still to emit
    logic [MAX_DEVICES-1:0] taken_reg, taken_next;
    dev_t               pick_reg  [MAX_DEVICES];   // chosen team, head at entry 0
    dev_t               pick_next [MAX_DEVICES];
    dev_t               pick_shift[MAX_DEVICES];
    logic [1:0]         err_reg, err_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    dev_t               out_dev_reg, out_dev_next;
    logic [1:0]         out_status_reg, out_status_next;
    logic               out_last_reg, out_last_next;

    // datapath
    logic [NUM_W-1:0]   n_dev;
    logic [NUM_W-1:0]   n_last;
    logic               at_end;
    logic [SCORE_W-1:0] cur_score;
    count_t             cur_cnt;
    logic               out_free;
    logic               cmp_gt;
    logic               take;
    dev_t               chosen;
    logic [SCORE_W-1:0] cmp_a_score, cmp_b_score;
    count_t             cmp_a_cnt, cmp_b_cnt;

    // devices present, counts above the table size act as full
    assign n_dev  = (device_count_reg > NUM_W'(MAX_DEVICES)) ? NUM_W'(MAX_DEVICES)
                                                             : device_count_reg;
    assign n_last = n_dev - NUM_W'(1);
    assign at_end = ({1'b0, ptr_reg} == n_last);

    assign cur_score = score_table_reg[{ptr_reg, 3'b000} +: SCORE_W];
    assign cur_cnt   = counts_reg[ptr_reg];
    assign out_free  = !out_valid_reg || out_ready;

    // single-pick asks "device i beats best"; team asks "best beats device i"
    always_comb
    begin
        if (state_reg == S_SCAN_TEAM)
        begin
            cmp_a_score = best_score_reg;
            cmp_a_cnt   = best_cnt_reg;
            cmp_b_score = cur_score;
            cmp_b_cnt   = cur_cnt;
        end
        else
        begin
            cmp_a_score = cur_score;
            cmp_a_cnt   = cur_cnt;
            cmp_b_score = best_score_reg;
            cmp_b_cnt   = best_cnt_reg;
        end
    end

    wlb_ratio_cmp u_cmp (
        .a_score   (cmp_a_score),
        .a_count   (cmp_a_cnt),
        .b_score   (cmp_b_score),
        .b_count   (cmp_b_cnt),
        .a_greater (cmp_gt)
    );

    // team scan: first candidate, or one the current best does not beat
    // (so equal ratios go to the later index)
    assign take   = !taken_reg[ptr_reg] && (!have_reg || !cmp_gt);
    assign chosen = take ? ptr_reg : best_idx_reg;

    always_comb
    begin
        pick_shift = pick_reg;
        for (int m = 0; m < MAX_DEVICES - 1; m++)
        begin
            pick_shift[m] = pick_reg[m + 1];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        best_idx_next   = best_idx_reg;
        best_score_next = best_score_reg;
        best_cnt_next   = best_cnt_reg;
        have_next       = have_reg;
        team_k_next     = team_k_reg;
        pick_cnt_next   = pick_cnt_reg;
        remain_next     = remain_reg;
        taken_next      = taken_reg;
        pick_next       = pick_reg;
        err_next        = err_reg;
        counts_next     = counts_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_dev_next    = out_dev_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        in_ready        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    priority if (func == FUNC_ACQ_ONE)
                    begin
                        // device 0 is the first best
                        ptr_next        = dev_t'(1);
                        best_idx_next   = '0;
                        best_score_next = score_table_reg[SCORE_W-1:0];
                        best_cnt_next   = counts_reg[0];
                        remain_next     = NUM_W'(1);
                        if (n_dev == '0)
                        begin
                            err_next   = ST_REJECT;
                            state_next = S_ERROR;
                        end
                        else if (n_dev == NUM_W'(1))
                        begin
                            ptr_next   = '0;
                            state_next = S_RAISE;
                        end
                        else
                        begin
                            state_next = S_SCAN_ONE;
                        end
                    end
                    else if (func == FUNC_ACQ_TEAM)
                    begin
                        if (team_size == '0 || team_size > n_dev)
                        begin
                            err_next   = ST_REJECT;
                            state_next = S_ERROR;
                        end
                        else
                        begin
                            team_k_next   = team_size;
                            pick_cnt_next = '0;
                            taken_next    = '0;
                            have_next     = 1'b0;
                            ptr_next      = '0;
                            state_next    = S_SCAN_TEAM;
                        end
                    end
                    else if (func == FUNC_RELEASE)
                    begin
                        if ({1'b0, device_index} >= n_dev)
                        begin
                            err_next   = ST_RANGE;
                            state_next = S_ERROR;
                        end
                        else
                        begin
                            ptr_next   = device_index;
                            state_next = S_RELEASE;
                        end
                    end
                    else
                    begin
                        // unused code: dropped
                        state_next = S_IDLE;
                    end
                end
            end

            S_SCAN_ONE:
            begin
                if (cmp_gt)
                begin
                    best_idx_next   = ptr_reg;
                    best_score_next = cur_score;
                    best_cnt_next   = cur_cnt;
                end
                if (at_end)
                begin
                    ptr_next   = cmp_gt ? ptr_reg : best_idx_reg;
                    state_next = S_RAISE;
                end
                else
                begin
                    ptr_next = ptr_reg + dev_t'(1);
                end
            end

            S_SCAN_TEAM:
            begin
                if (take)
                begin
                    best_idx_next   = ptr_reg;
                    best_score_next = cur_score;
                    best_cnt_next   = cur_cnt;
                    have_next       = 1'b1;
                end
                if (at_end)
                begin
                    taken_next[chosen]            = 1'b1;
                    pick_next[pick_cnt_reg[2:0]]  = chosen;
                    pick_cnt_next                 = pick_cnt_reg + NUM_W'(1);
                    have_next                     = 1'b0;
                    if (pick_cnt_reg + NUM_W'(1) == team_k_reg)
                    begin
                        // all picks judged; now raise and report in order
                        ptr_next    = (pick_cnt_reg == '0) ? chosen : pick_reg[0];
                        pick_next[0] = (pick_cnt_reg == '0) ? chosen : pick_reg[0];
                        remain_next = team_k_reg;
                        state_next  = S_RAISE;
                    end
                    else
                    begin
                        ptr_next = '0;
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + dev_t'(1);
                end
            end

            S_RAISE:
            begin
                if (out_free)
                begin
                    if (cur_cnt != '1)
                    begin
                        counts_next[ptr_reg] = cur_cnt + count_t'(1);
                    end
                    out_valid_next  = 1'b1;
                    out_dev_next    = ptr_reg;
                    out_status_next = ST_OK;
                    out_last_next   = (remain_reg == NUM_W'(1));
                    remain_next     = remain_reg - NUM_W'(1);
                    pick_next       = pick_shift;
                    ptr_next        = pick_shift[0];
                    if (remain_reg == NUM_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_RELEASE:
            begin
                if (out_free)
                begin
                    if (cur_cnt != '0)
                    begin
                        counts_next[ptr_reg] = cur_cnt - count_t'(1);
                    end
                    out_valid_next  = 1'b1;
                    out_dev_next    = ptr_reg;
                    out_status_next = ST_OK;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            S_ERROR:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_dev_next    = '0;
                    out_status_next = err_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // configuration registers, to be written only while idle; the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_table_reg  <= '0;
            device_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SCORE_TABLE:  score_table_reg  <= cfg_data;
                REG_DEVICE_COUNT: device_count_reg <= cfg_data[NUM_W-1:0];
                default:          score_table_reg  <= score_table_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            counts_reg     <= '{default: '0};
            taken_reg      <= '0;
            have_reg       <= 1'b0;
            pick_cnt_reg   <= '0;
            remain_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            counts_reg     <= counts_next;
            taken_reg      <= taken_next;
            have_reg       <= have_next;
            pick_cnt_reg   <= pick_cnt_next;
            remain_reg     <= remain_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        best_idx_reg   <= best_idx_next;
        best_score_reg <= best_score_next;
        best_cnt_reg   <= best_cnt_next;
        team_k_reg     <= team_k_next;
        pick_reg       <= pick_next;
        err_reg        <= err_next;
        out_dev_reg    <= out_dev_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid     = out_valid_reg;
    assign chosen_device = out_dev_reg;
    assign status        = out_status_reg;
    assign last          = out_last_reg;

endmodule

// ----- bench/tb_weighted_load_balancer.sv -----
`timescale 1ns / 100ps
// tb_weighted_load_balancer: self-checking bench for the weighted load balancer.
// Keeps its own copy of scores, device count and session counts; needs wlb_pkg
// and the weighted_load_balancer RTL.

module tb_weighted_load_balancer;
    import wlb_pkg::*;

    // request code the block must ignore
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    // receiver hold-off long enough to back the block up
    localparam int LONG_HOLD     = 300;
    // worst request is a team of 8 over 8 devices
    localparam int SETTLE_CYCLES = 100;
    // single acquires piled onto one device
    localparam int PILE_ITEMS    = 20;
    // cap on printed mismatch lines
    localparam int REPORT_CAP    = 100;

    typedef struct packed {
        logic [1:0] func;
        logic [3:0] team_size;
        logic [2:0] device_index;
    } request_t;

    typedef struct packed {
        dev_t       device;
        logic [1:0] status;
        logic       last;
    } grant_t;

    // ---------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ---------------------------------------------------------------
    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [CFG_W-1:0]     cfg_data      = '0;
    logic                 in_valid      = 1'b0;
    logic                 in_ready;
    logic [1:0]           func          = '0;
    logic [3:0]           team_size     = '0;
    logic [2:0]           device_index  = '0;
    logic                 out_valid;
    logic                 out_ready     = 1'b0;
    logic [2:0]           chosen_device;
    logic [1:0]           status;
    logic                 last;

    weighted_load_balancer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .team_size     (team_size),
        .device_index  (device_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .chosen_device (chosen_device),
        .status        (status),
        .last          (last)
    );

    // ---------------------------------------------------------------
    // Bench copy of the block's state
    // ---------------------------------------------------------------
    logic [CFG_W-1:0] score_cfg = '0;
    logic [NUM_W-1:0] count_cfg = '0;
    count_t           sessions [MAX_DEVICES];

    request_t request_backlog [$];  // items waiting for the driver
    grant_t   awaited_grants  [$];  // results predicted, not yet seen

    int requests_queued   = 0;
    int requests_accepted = 0;
    int grants_checked    = 0;
    int errors            = 0;
    int settings_used     = 0;
    int idle_pct          = 0;      // chance per free cycle of an idle burst
    int holds_asked       = 0;      // long receiver hold-offs requested
    int holds_done        = 0;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic int devices_present();
        return (count_cfg > MAX_DEVICES) ? MAX_DEVICES : int'(count_cfg);
    endfunction

    function automatic logic [SCORE_W-1:0] score_of(input int dev);
        return score_cfg[dev*SCORE_W +: SCORE_W];
    endfunction

    // score_a/(sess_a+1) > score_b/(sess_b+1), cross-multiplied so it is exact
    function automatic bit ratio_greater(input int a, input int b);
        logic [PROD_W-1:0] lhs;
        logic [PROD_W-1:0] rhs;
        lhs = PROD_W'(score_of(a)) * (PROD_W'(sessions[b]) + PROD_W'(1));
        rhs = PROD_W'(score_of(b)) * (PROD_W'(sessions[a]) + PROD_W'(1));
        return lhs > rhs;
    endfunction

    // saturating raise
    function automatic void raise_sessions(input int dev);
        if (sessions[dev] != '1)
            sessions[dev] = sessions[dev] + 1'b1;
    endfunction

    function automatic void push_grant(input int dev, input logic [1:0] st, input logic fin);
        grant_t g;
        g.device = dev_t'(dev);
        g.status = st;
        g.last   = fin;
        awaited_grants = {awaited_grants, g};
    endfunction

    function automatic void predict_grants(input request_t req);
        int n;
        int k;
        int idx;
        int best;
        bit have;
        bit taken [MAX_DEVICES];
        int pick  [MAX_DEVICES];
        n   = devices_present();
        k   = int'(req.team_size);
        idx = int'(req.device_index);
        case (req.func)
            FUNC_ACQ_ONE:
            begin
                if (n == 0)
                    push_grant(0, ST_REJECT, 1'b1);
                else
                begin
                    // strict compare: lower index keeps ties
                    best = 0;
                    for (int i = 1; i < n; i++)
                        if (ratio_greater(i, best))
                            best = i;
                    raise_sessions(best);
                    push_grant(best, ST_OK, 1'b1);
                end
            end
            FUNC_ACQ_TEAM:
            begin
                if (k == 0 || k > n)
                    push_grant(0, ST_REJECT, 1'b1);
                else
                begin
                    foreach (taken[i])
                        taken[i] = 1'b0;
                    // whole team is ranked on the counts as they stand
                    for (int j = 0; j < k; j++)
                    begin
                        have = 1'b0;
                        best = 0;
                        for (int i = 0; i < n; i++)
                            if (!taken[i] && (!have || !ratio_greater(best, i)))
                            begin
                                best = i;   // higher index wins ties
                                have = 1'b1;
                            end
                        taken[best] = 1'b1;
                        pick[j]     = best;
                    end
                    for (int j = 0; j < k; j++)
                    begin
                        raise_sessions(pick[j]);
                        push_grant(pick[j], ST_OK, j == k - 1);
                    end
                end
            end
            FUNC_RELEASE:
            begin
                if (idx >= n)
                    push_grant(0, ST_RANGE, 1'b1);
                else
                begin
                    if (sessions[idx] != '0)
                        sessions[idx] = sessions[idx] - 1'b1;
                    push_grant(idx, ST_OK, 1'b1);
                end
            end
            default: ;  // unused code: no result, no state change
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Clock
    // ---------------------------------------------------------------
    initial
    begin
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Driver: offers backlog items, predicts on acceptance
    // ---------------------------------------------------------------
    request_t offered;
    int       gap_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                // predict before counting so the idle check never runs ahead
                predict_grants(offered);
                requests_accepted++;
            end
            // only move on once the current item is gone
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
                begin
                    gap_left = $urandom_range(1, 17) - 1;
                    in_valid <= 1'b0;
                end
                else if (request_backlog.size() > 0)
                begin
                    offered = request_backlog.pop_front();
                    in_valid     <= 1'b1;
                    func         <= offered.func;
                    team_size    <= offered.team_size;
                    device_index <= offered.device_index;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: checks results against the oldest prediction
    // ---------------------------------------------------------------
    grant_t due;
    int     hold_left  = 0;
    int     stall_left = 0;

    function automatic void note_mismatch(input string field, input logic [7:0] exp_v,
                                          input logic [7:0] act_v);
        errors++;
        if (errors <= REPORT_CAP)
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, exp_v, act_v);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_grants.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_CAP)
                        $display("%0t: unawaited result: expected none, actual %0d/%0d/%0d",
                                 $time, chosen_device, status, last);
                end
                else
                begin
                    due = awaited_grants.pop_front();
                    grants_checked++;
                    if (chosen_device !== due.device)
                        note_mismatch("chosen_device", 8'(due.device), 8'(chosen_device));
                    if (status !== due.status)
                        note_mismatch("status", 8'(due.status), 8'(status));
                    if (last !== due.last)
                        note_mismatch("last", 8'(due.last), 8'(last));
                end
            end
            // ready policy: long hold-off first, then random bursts
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (holds_done < holds_asked)
            begin
                holds_done++;
                hold_left = LONG_HOLD - 1;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            begin
                stall_left = $urandom_range(1, 17) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic queue_request(input logic [1:0] f, input int k, input int dev);
        request_t r;
        r.func         = f;
        r.team_size    = 4'(k);
        r.device_index = 3'(dev);
        request_backlog = {request_backlog, r};
        requests_queued++;
    endtask

    // all items taken, all results in, then let a possible ignored item drain
    task automatic wait_for_idle();
        while (requests_accepted != requests_queued || awaited_grants.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_SCORE_TABLE)
            score_cfg = value;
        else
            count_cfg = value[NUM_W-1:0];
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] scores, input logic [NUM_W-1:0] count);
        wait_for_idle();
        write_reg(REG_SCORE_TABLE, scores);
        // junk above the count field must be dropped
        write_reg(REG_DEVICE_COUNT, {32'($urandom), 28'($urandom), count});
        settings_used++;
    endtask

    // mostly in-range requests, some rejects and a few ignored codes
    task automatic random_phase(input int items);
        int n;
        int r;
        int placed;
        n      = devices_present();
        placed = 0;
        while (placed < items)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                queue_request(FUNC_UNUSED, $urandom_range(0, 15), $urandom_range(0, 7));
            else
            begin
                placed++;
                if (r < 42)
                    queue_request(FUNC_ACQ_ONE, $urandom_range(0, 15), $urandom_range(0, 7));
                else if (r < 68)
                    queue_request(FUNC_ACQ_TEAM,
                                  (n == 0 || $urandom_range(0, 9) == 0) ?
                                      $urandom_range(0, 15) : $urandom_range(1, n),
                                  $urandom_range(0, 7));
                else
                    queue_request(FUNC_RELEASE, $urandom_range(0, 15),
                                  (n == 0 || $urandom_range(0, 9) == 0) ?
                                      $urandom_range(0, 7) : $urandom_range(0, n - 1));
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        logic [CFG_W-1:0] scores;
        logic [NUM_W-1:0] count;
        int               count_plan [6];
        foreach (sessions[i])
            sessions[i] = '0;
        count_plan = '{8, 2, 9, 1, 0, 8};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: nothing configured, so no devices at all
        queue_request(FUNC_ACQ_ONE, 0, 0);
        queue_request(FUNC_ACQ_TEAM, 1, 0);
        queue_request(FUNC_RELEASE, 0, 0);
        queue_request(FUNC_UNUSED, 15, 7);

        // distinct scores, one dead device, full table
        apply_settings(64'h01FF_8040_00C8_2010, 4'd8);
        queue_request(FUNC_RELEASE, 0, 3);      // release of an unused device
        queue_request(FUNC_ACQ_ONE, 0, 0);
        queue_request(FUNC_ACQ_ONE, 15, 7);
        queue_request(FUNC_ACQ_ONE, 0, 0);
        queue_request(FUNC_ACQ_TEAM, 8, 0);     // whole table
        queue_request(FUNC_ACQ_TEAM, 0, 0);     // empty team
        queue_request(FUNC_ACQ_TEAM, 9, 0);     // team larger than table
        queue_request(FUNC_ACQ_TEAM, 15, 7);
        queue_request(FUNC_RELEASE, 15, 1);
        queue_request(FUNC_RELEASE, 0, 7);

        // every ratio zero
        apply_settings('0, 4'd4);
        queue_request(FUNC_ACQ_ONE, 0, 0);
        queue_request(FUNC_ACQ_ONE, 0, 0);
        queue_request(FUNC_ACQ_TEAM, 4, 0);
        queue_request(FUNC_RELEASE, 0, 7);      // beyond count
        queue_request(FUNC_RELEASE, 0, 4);      // just beyond count

        // equal scores, count field above the device limit
        apply_settings('1, 4'd15);
        queue_request(FUNC_ACQ_TEAM, 8, 0);
        queue_request(FUNC_ACQ_ONE, 0, 0);
        queue_request(FUNC_ACQ_TEAM, 3, 0);
        queue_request(FUNC_RELEASE, 0, 6);

        // Random phases over varied tables and counts
        for (int p = 0; p < 6; p++)
        begin
            scores = {$urandom, $urandom};
            case (p % 4)
                1:  // one shared score: ties everywhere
                begin
                    for (int i = 0; i < MAX_DEVICES; i++)
                        scores[i*SCORE_W +: SCORE_W] = scores[SCORE_W-1:0];
                end
                2:  // some dead devices
                begin
                    for (int i = 0; i < MAX_DEVICES; i++)
                        if ($urandom_range(0, 2) == 0)
                            scores[i*SCORE_W +: SCORE_W] = '0;
                end
                3:  // tiny scores, many equal ratios
                begin
                    for (int i = 0; i < MAX_DEVICES; i++)
                        scores[i*SCORE_W +: SCORE_W] = SCORE_W'($urandom_range(0, 3));
                end
                default: ;
            endcase
            count = (p == 4) ? 4'($urandom_range(0, 15)) : 4'(count_plan[p]);
            apply_settings(scores, count);
            idle_pct = (p == 3) ? 0 : ((p % 2 == 1) ? 25 : 8);
            // first phase: receiver backs off while items keep coming
            if (p == 0)
                holds_asked++;
            random_phase(60);
        end

        // Last part, no idling: pile sessions onto a single device
        idle_pct = 0;
        apply_settings({$urandom, $urandom}, 4'd1);
        for (int i = 0; i < PILE_ITEMS; i++)
            queue_request(FUNC_ACQ_ONE, $urandom_range(0, 15), $urandom_range(0, 7));
        queue_request(FUNC_RELEASE, 0, 0);
        queue_request(FUNC_ACQ_ONE, 0, 0);
        queue_request(FUNC_ACQ_ONE, 0, 0);

        // ratios against one heavily loaded device
        apply_settings({$urandom, $urandom}, 4'd2);
        random_phase(40);
        wait_for_idle();

        $display("Covered %0d requests and %0d results over %0d register settings,",
                 requests_accepted, grants_checked, settings_used);
        $display("with idle bursts, a long output hold-off and sessions piled on one device.");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // ---------------------------------------------------------------
    // Watchdog: far beyond the slowest correct run
    // ---------------------------------------------------------------
    initial
    begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
